[sv/bgps_pkg.sv]
// ----------------------------------------------------------------------------
// bgps_pkg
// Shared constants for the barycentric Gouraud pixel shader.
// ----------------------------------------------------------------------------
package bgps_pkg;

	// Default coordinate width of vertices and pixels
	localparam int COORD_BITS_DEF = 12;

	// One color channel and the packing of three channels into a vertex color
	localparam int CHAN_BITS  = 8;
	localparam int NUM_CHAN   = 3;
	localparam int COLOR_BITS = CHAN_BITS * NUM_CHAN;

	// Channel positions inside a packed color
	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	// Vertices per triangle, and edge functions formed: twice the area plus one per edge
	localparam int NUM_VERT = 3;
	localparam int NUM_EDGE = NUM_VERT + 1;

endpackage

[sv/barycentric_gouraud_pixel_shader_top.sv]
// ----------------------------------------------------------------------------
// barycentric_gouraud_pixel_shader_top
// Per-pixel triangle coverage test with Gouraud color interpolation.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output side does not stall: a triangle,
// its three vertex colors and one pixel. Six stages form the edge
// functions, coverage and the weighted color sums. Eight stages divide each
// channel sum by twice the triangle area, one quotient bit per stage in three
// parallel restoring dividers. Every stage has its own valid bit and ready
// is chained backward, so a stalled output only holds the stages that are
// full; empty stages keep filling. A pixel on an edge or vertex, or any
// pixel of a zero-area triangle, is reported not covered with black color.
module barycentric_gouraud_pixel_shader_top #(
	parameter int COORD_BITS = bgps_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_BITS-1:0]          vert0_x,
	input  logic signed [COORD_BITS-1:0]          vert0_y,
	input  logic signed [COORD_BITS-1:0]          vert1_x,
	input  logic signed [COORD_BITS-1:0]          vert1_y,
	input  logic signed [COORD_BITS-1:0]          vert2_x,
	input  logic signed [COORD_BITS-1:0]          vert2_y,
	input  logic [bgps_pkg::COLOR_BITS-1:0]       color0,
	input  logic [bgps_pkg::COLOR_BITS-1:0]       color1,
	input  logic [bgps_pkg::COLOR_BITS-1:0]       color2,
	input  logic signed [COORD_BITS-1:0]          pixel_x,
	input  logic signed [COORD_BITS-1:0]          pixel_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [COORD_BITS-1:0]          out_x,
	output logic signed [COORD_BITS-1:0]          out_y,
	output logic                                  covered,
	output logic [bgps_pkg::CHAN_BITS-1:0]        red,
	output logic [bgps_pkg::CHAN_BITS-1:0]        green,
	output logic [bgps_pkg::CHAN_BITS-1:0]        blue
);

	localparam int CB   = bgps_pkg::CHAN_BITS;
	localparam int NCH  = bgps_pkg::NUM_CHAN;
	localparam int NV   = bgps_pkg::NUM_VERT;
	localparam int NE   = bgps_pkg::NUM_EDGE;
	localparam int DW   = COORD_BITS + 1;        // coordinate difference
	localparam int PW   = 2 * COORD_BITS + 2;    // difference product
	localparam int EW   = 2 * COORD_BITS + 3;    // edge function
	localparam int MW   = 2 * COORD_BITS + 2;    // edge magnitude
	localparam int NW   = MW + CB;               // channel numerator
	localparam int DIV  = CB;                    // one quotient bit per stage
	localparam int NSTG = 6 + DIV;

	// ------------------------------------------------------------------------
	// Stage handshake
	// ------------------------------------------------------------------------
	logic [NSTG:1]   vld_q;
	logic [NSTG:1]   vld_prev;
	logic [NSTG+1:1] adv;

	assign adv[NSTG+1] = out_ready;
	for (genvar k = 1; k <= NSTG; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end

	assign vld_prev = {vld_q[NSTG-1:1], in_valid};
	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_prev & adv[NSTG:1]) | (vld_q & ~adv[NSTG:1]);
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: coordinate differences per edge function
	// Edge 0 is twice the area (pixel replaced by vertex 0), edges 1..3 are e0..e2.
	// ------------------------------------------------------------------------
	logic signed [COORD_BITS-1:0] src_ax [NE];
	logic signed [COORD_BITS-1:0] src_ay [NE];
	logic signed [COORD_BITS-1:0] src_bx [NE];
	logic signed [COORD_BITS-1:0] src_by [NE];
	logic signed [COORD_BITS-1:0] src_px [NE];
	logic signed [COORD_BITS-1:0] src_py [NE];

	always_comb begin
		src_ax[0] = vert1_x;  src_ay[0] = vert1_y;
		src_bx[0] = vert2_x;  src_by[0] = vert2_y;
		src_px[0] = vert0_x;  src_py[0] = vert0_y;
		src_ax[1] = vert1_x;  src_ay[1] = vert1_y;
		src_bx[1] = vert2_x;  src_by[1] = vert2_y;
		src_px[1] = pixel_x;  src_py[1] = pixel_y;
		src_ax[2] = vert2_x;  src_ay[2] = vert2_y;
		src_bx[2] = vert0_x;  src_by[2] = vert0_y;
		src_px[2] = pixel_x;  src_py[2] = pixel_y;
		src_ax[3] = vert0_x;  src_ay[3] = vert0_y;
		src_bx[3] = vert1_x;  src_by[3] = vert1_y;
		src_px[3] = pixel_x;  src_py[3] = pixel_y;
	end

	logic signed [DW-1:0]         dx_s1 [NE];
	logic signed [DW-1:0]         dy_s1 [NE];
	logic signed [DW-1:0]         qx_s1 [NE];
	logic signed [DW-1:0]         qy_s1 [NE];
	logic [bgps_pkg::COLOR_BITS-1:0] clr_s1 [NV];
	logic signed [COORD_BITS-1:0] x_s1, y_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int e = 0; e < NE; e++) begin
				dx_s1[e] <= DW'(src_bx[e]) - DW'(src_ax[e]);
				dy_s1[e] <= DW'(src_by[e]) - DW'(src_ay[e]);
				qx_s1[e] <= DW'(src_px[e]) - DW'(src_ax[e]);
				qy_s1[e] <= DW'(src_py[e]) - DW'(src_ay[e]);
			end
			clr_s1[0] <= color0;
			clr_s1[1] <= color1;
			clr_s1[2] <= color2;
			x_s1      <= pixel_x;
			y_s1      <= pixel_y;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 2: cross products, f = dx*qy - dy*qx
	// ------------------------------------------------------------------------
	logic signed [PW-1:0]            pa_s2 [NE];
	logic signed [PW-1:0]            pb_s2 [NE];
	logic [bgps_pkg::COLOR_BITS-1:0] clr_s2 [NV];
	logic signed [COORD_BITS-1:0]    x_s2, y_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int e = 0; e < NE; e++) begin
				pa_s2[e] <= PW'(dx_s1[e]) * PW'(qy_s1[e]);
				pb_s2[e] <= PW'(dy_s1[e]) * PW'(qx_s1[e]);
			end
			clr_s2 <= clr_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 3: edge functions
	// ------------------------------------------------------------------------
	logic signed [EW-1:0]            edge_s3 [NE];
	logic [bgps_pkg::COLOR_BITS-1:0] clr_s3 [NV];
	logic signed [COORD_BITS-1:0]    x_s3, y_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int e = 0; e < NE; e++) begin
				edge_s3[e] <= EW'(pa_s2[e]) - EW'(pb_s2[e]);
			end
			clr_s3 <= clr_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 4: coverage and magnitudes
	// ------------------------------------------------------------------------
	logic                 area_pos, area_neg, cov_c;
	logic [NV-1:0]        inside_c;
	logic signed [EW-1:0] abs_c [NE];

	always_comb begin
		area_pos = !edge_s3[0][EW-1] && (edge_s3[0] != '0);
		area_neg = edge_s3[0][EW-1];
		for (int i = 0; i < NV; i++) begin
			if (area_pos) begin
				inside_c[i] = !edge_s3[i+1][EW-1] && (edge_s3[i+1] != '0) &&
					(edge_s3[i+1] < edge_s3[0]);
			end else begin
				inside_c[i] = area_neg && edge_s3[i+1][EW-1] &&
					(edge_s3[i+1] > edge_s3[0]);
			end
		end
		cov_c = &inside_c;
		for (int e = 0; e < NE; e++) begin
			abs_c[e] = edge_s3[e][EW-1] ? -edge_s3[e] : edge_s3[e];
		end
	end

	logic [MW-1:0]                   w_s4 [NV];
	logic [MW-1:0]                   d_s4;
	logic                            cov_s4;
	logic [bgps_pkg::COLOR_BITS-1:0] clr_s4 [NV];
	logic signed [COORD_BITS-1:0]    x_s4, y_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			// zero the weights of an uncovered pixel so its sums are zero
			for (int i = 0; i < NV; i++) begin
				w_s4[i] <= cov_c ? abs_c[i+1][MW-1:0] : '0;
			end
			d_s4   <= abs_c[0][MW-1:0];
			cov_s4 <= cov_c;
			clr_s4 <= clr_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 5: weight times channel
	// ------------------------------------------------------------------------
	logic [NW-1:0]                prod_s5 [NCH][NV];
	logic [MW-1:0]                d_s5;
	logic                         cov_s5;
	logic signed [COORD_BITS-1:0] x_s5, y_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int ch = 0; ch < NCH; ch++) begin
				for (int i = 0; i < NV; i++) begin
					prod_s5[ch][i] <= NW'(w_s4[i]) * NW'(clr_s4[i][ch*CB +: CB]);
				end
			end
			d_s5   <= d_s4;
			cov_s5 <= cov_s4;
			x_s5   <= x_s4;
			y_s5   <= y_s4;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 6: channel numerators; below 2^CB times the area for a covered pixel
	// ------------------------------------------------------------------------
	logic [NW-1:0]                num_s6 [NCH];
	logic [MW-1:0]                d_s6;
	logic                         cov_s6;
	logic signed [COORD_BITS-1:0] x_s6, y_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int ch = 0; ch < NCH; ch++) begin
				num_s6[ch] <= prod_s5[ch][0] + prod_s5[ch][1] + prod_s5[ch][2];
			end
			d_s6   <= d_s5;
			cov_s6 <= cov_s5;
			x_s6   <= x_s5;
			y_s6   <= y_s5;
		end
	end

	// ------------------------------------------------------------------------
	// Stages 7..14: restoring division, MSB of the quotient first
	// ------------------------------------------------------------------------
	logic [NW-1:0]                dv_rem_s [DIV][NCH];
	logic [CB-1:0]                dv_q_s   [DIV][NCH];
	logic [MW-1:0]                dv_d_s   [DIV];
	logic                         dv_cov_s [DIV];
	logic signed [COORD_BITS-1:0] dv_x_s   [DIV];
	logic signed [COORD_BITS-1:0] dv_y_s   [DIV];

	for (genvar j = 0; j < DIV; j++) begin : g_div
		localparam int SH = CB - 1 - j;

		logic [NW-1:0]                rem_in [NCH];
		logic [CB-1:0]                q_in   [NCH];
		logic [MW-1:0]                d_in;
		logic                         cov_in;
		logic signed [COORD_BITS-1:0] x_in, y_in;
		logic [NW-1:0]                dsh;
		logic [NW-1:0]                rem_nx [NCH];
		logic [CB-1:0]                q_nx   [NCH];

		if (j == 0) begin : g_first
			always_comb begin
				for (int ch = 0; ch < NCH; ch++) begin
					rem_in[ch] = num_s6[ch];
					q_in[ch]   = '0;
				end
				d_in   = d_s6;
				cov_in = cov_s6;
				x_in   = x_s6;
				y_in   = y_s6;
			end
		end else begin : g_next
			always_comb begin
				for (int ch = 0; ch < NCH; ch++) begin
					rem_in[ch] = dv_rem_s[j-1][ch];
					q_in[ch]   = dv_q_s[j-1][ch];
				end
				d_in   = dv_d_s[j-1];
				cov_in = dv_cov_s[j-1];
				x_in   = dv_x_s[j-1];
				y_in   = dv_y_s[j-1];
			end
		end

		always_comb begin
			dsh = NW'(d_in) << SH;
			for (int ch = 0; ch < NCH; ch++) begin
				if (rem_in[ch] >= dsh) begin
					rem_nx[ch] = rem_in[ch] - dsh;
					q_nx[ch]   = {q_in[ch][CB-2:0], 1'b1};
				end else begin
					rem_nx[ch] = rem_in[ch];
					q_nx[ch]   = {q_in[ch][CB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[7+j]) begin
				dv_rem_s[j] <= rem_nx;
				dv_q_s[j]   <= q_nx;
				dv_d_s[j]   <= d_in;
				dv_cov_s[j] <= cov_in;
				dv_x_s[j]   <= x_in;
				dv_y_s[j]   <= y_in;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output
	// ------------------------------------------------------------------------
	assign out_valid = vld_q[NSTG];
	assign out_x     = dv_x_s[DIV-1];
	assign out_y     = dv_y_s[DIV-1];
	assign covered   = dv_cov_s[DIV-1];
	// a zero area divides to all ones, so drop the color when not covered
	assign red   = dv_cov_s[DIV-1] ? dv_q_s[DIV-1][bgps_pkg::CH_RED]   : '0;
	assign green = dv_cov_s[DIV-1] ? dv_q_s[DIV-1][bgps_pkg::CH_GREEN] : '0;
	assign blue  = dv_cov_s[DIV-1] ? dv_q_s[DIV-1][bgps_pkg::CH_BLUE]  : '0;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_edge_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> (EW'(edge_s3[1] + edge_s3[2] + edge_s3[3]) == edge_s3[0]))
		else $error("edge functions do not add up to twice the area");

	a_weights: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] && cov_s4 |-> (w_s4[0] < d_s4) && (w_s4[1] < d_s4) && (w_s4[2] < d_s4) &&
			(MW'(w_s4[0] + w_s4[1] + w_s4[2]) == d_s4))
		else $error("covered pixel weights out of range");

	a_num_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[6] && cov_s6 |-> (num_s6[0] < (NW'(d_s6) << CB)) &&
			(num_s6[1] < (NW'(d_s6) << CB)) && (num_s6[2] < (NW'(d_s6) << CB)))
		else $error("channel numerator exceeds quotient range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && covered |-> (dv_rem_s[DIV-1][0] < NW'(dv_d_s[DIV-1])) &&
			(dv_rem_s[DIV-1][1] < NW'(dv_d_s[DIV-1])) &&
			(dv_rem_s[DIV-1][2] < NW'(dv_d_s[DIV-1])))
		else $error("division remainder not below divisor");

endmodule
